/* design/smb_pkg.sv */
// shared constants, types and helper functions of the stabilization matrix builder
package smb_pkg;

    localparam int ATAN_COUNT = 24;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;

    localparam logic [15:0] RAW_MIN_Q12  = 16'd41;
    localparam logic [26:0] CORR_MIN_Q16 = 27'd655;
    localparam logic [26:0] UNITY_Q16    = 27'd65536;

    localparam logic signed [44:0] OUT_MAX = 45'sd8388607;
    localparam logic signed [44:0] OUT_MIN = -45'sd8388608;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_ENABLE_X,
        CFG_ENABLE_Y,
        CFG_ENABLE_ZOOM,
        CFG_ENABLE_ROTATION,
        CFG_ENABLE_SCALE
    } t_cfg_idx;

    function automatic logic [30:0] atan_q30(input int unsigned i);
        logic [30:0] v;
        case (i)
            0:       v = 31'd843314856;
            1:       v = 31'd497837829;
            2:       v = 31'd263043836;
            3:       v = 31'd133525158;
            4:       v = 31'd67021686;
            5:       v = 31'd33543515;
            6:       v = 31'd16775850;
            7:       v = 31'd8388437;
            8:       v = 31'd4194282;
            9:       v = 31'd2097149;
            10:      v = 31'd1048575;
            11:      v = 31'd524287;
            12:      v = 31'd262143;
            13:      v = 31'd131071;
            14:      v = 31'd65535;
            15:      v = 31'd32767;
            16:      v = 31'd16383;
            17:      v = 31'd8191;
            18:      v = 31'd4095;
            19:      v = 31'd2047;
            20:      v = 31'd1023;
            21:      v = 31'd511;
            22:      v = 31'd255;
            23:      v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [44:0] v);
        logic signed [23:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[23:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[23:0];
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

/* design/smb_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
module smb_div #(
    parameter int ND = 32,
    parameter int DW = 16,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [ND-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [ND-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [DW-1:0] r_rem [ND];
    logic [ND-1:0] r_num [ND];
    logic [ND-1:0] r_quo [ND];
    logic [DW-1:0] r_den [ND];
    logic [PW-1:0] r_pay [ND];
    logic          r_vld [ND];

    for (genvar g = 0; g < ND; g++) begin : g_stage
        logic [DW-1:0] p_rem;
        logic [ND-1:0] p_num;
        logic [ND-1:0] p_quo;
        logic [DW-1:0] p_den;
        logic [PW-1:0] p_pay;
        logic          p_vld;
        logic [DW:0]   trial;
        logic          ge;

        if (g == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_pay = i_pay;
            assign p_vld = i_vld;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_num = r_num[g-1];
            assign p_quo = r_quo[g-1];
            assign p_den = r_den[g-1];
            assign p_pay = r_pay[g-1];
            assign p_vld = r_vld[g-1];
        end

        assign trial = {p_rem, p_num[ND-1]};
        assign ge    = (trial >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
                r_num[g] <= {p_num[ND-2:0], 1'b0};
                r_quo[g] <= {p_quo[ND-2:0], ge};
                r_den[g] <= p_den;
                r_pay[g] <= p_pay;
            end
        end
    end

    assign o_vld = r_vld[ND-1];
    assign o_quo = r_quo[ND-1];
    assign o_pay = r_pay[ND-1];

endmodule

/* design/smb_cordic.sv */
// pipelined rotation-mode cordic with angle wrap and quadrant fold
module smb_cordic #(
    parameter int NS = 16,
    parameter int PW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [16:0]  i_rot,
    input  logic [PW-1:0]       i_pay,
    output logic                o_vld,
    output logic signed [32:0]  o_cs,
    output logic signed [32:0]  o_sn,
    output logic [PW-1:0]       o_pay
);

    logic signed [35:0] n_a0, n_a1, n_a;
    logic signed [35:0] r_a;
    logic [PW-1:0]      r_pay_a;
    logic               r_vld_a;

    logic signed [35:0] n_zf;
    logic               n_negf;
    logic signed [32:0] r_z0;
    logic               r_neg0;
    logic [PW-1:0]      r_pay0;
    logic               r_vld0;

    logic signed [32:0] r_x [NS];
    logic signed [32:0] r_y [NS];
    logic signed [32:0] r_z [NS];
    logic               r_neg [NS];
    logic [PW-1:0]      r_pay [NS];
    logic               r_vld [NS];

    logic signed [32:0] r_cs, r_sn;
    logic [PW-1:0]      r_pay_o;
    logic               r_vld_o;

    // a = -rot in q30, then wrapped once into [-pi, pi]
    always_comb begin
        n_a0 = -(36'(i_rot) <<< 17);
        n_a1 = (n_a0 > smb_pkg::PI_Q30) ? n_a0 - smb_pkg::TWO_PI_Q30 : n_a0;
        n_a  = (n_a1 < -smb_pkg::PI_Q30) ? n_a1 + smb_pkg::TWO_PI_Q30 : n_a1;
    end

    always_comb begin
        n_zf   = r_a;
        n_negf = 1'b0;
        if (r_a > smb_pkg::HALF_PI_Q30) begin
            n_zf   = r_a - smb_pkg::PI_Q30;
            n_negf = 1'b1;
        end else if (r_a < -smb_pkg::HALF_PI_Q30) begin
            n_zf   = r_a + smb_pkg::PI_Q30;
            n_negf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld0  <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld0  <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= n_a;
            r_pay_a <= i_pay;
            r_z0    <= n_zf[32:0];
            r_neg0  <= n_negf;
            r_pay0  <= r_pay_a;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic signed [32:0] p_x, p_y, p_z;
        logic               p_neg;
        logic [PW-1:0]      p_pay;
        logic               p_vld;
        logic signed [32:0] at;

        if (g == 0) begin : g_first
            assign p_x   = smb_pkg::GAIN_Q30;
            assign p_y   = '0;
            assign p_z   = r_z0;
            assign p_neg = r_neg0;
            assign p_pay = r_pay0;
            assign p_vld = r_vld0;
        end else begin : g_next
            assign p_x   = r_x[g-1];
            assign p_y   = r_y[g-1];
            assign p_z   = r_z[g-1];
            assign p_neg = r_neg[g-1];
            assign p_pay = r_pay[g-1];
            assign p_vld = r_vld[g-1];
        end

        assign at = $signed({2'b00, smb_pkg::atan_q30(g)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!p_z[32]) begin
                    r_x[g] <= p_x - (p_y >>> g);
                    r_y[g] <= p_y + (p_x >>> g);
                    r_z[g] <= p_z - at;
                end else begin
                    r_x[g] <= p_x + (p_y >>> g);
                    r_y[g] <= p_y - (p_x >>> g);
                    r_z[g] <= p_z + at;
                end
                r_neg[g] <= p_neg;
                r_pay[g] <= p_pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_o <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs    <= r_neg[NS-1] ? -r_x[NS-1] : r_x[NS-1];
            r_sn    <= r_neg[NS-1] ? -r_y[NS-1] : r_y[NS-1];
            r_pay_o <= r_pay[NS-1];
        end
    end

    assign o_vld = r_vld_o;
    assign o_cs  = r_cs;
    assign o_sn  = r_sn;
    assign o_pay = r_pay_o;

endmodule

/* design/smb_mat.sv */
// matrix term pipeline: scale products, rounding, centre offsets and saturation
module smb_mat (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [22:0]        i_s,
    input  logic signed [32:0] i_cs,
    input  logic signed [32:0] i_sn,
    input  logic signed [20:0] i_tx,
    input  logic signed [20:0] i_ty,
    input  logic [13:0]        i_w,
    input  logic [13:0]        i_h,
    output logic               o_vld,
    output logic signed [23:0] o_m00,
    output logic signed [23:0] o_m01,
    output logic signed [23:0] o_m02,
    output logic signed [23:0] o_m10,
    output logic signed [23:0] o_m11,
    output logic signed [23:0] o_m12
);

    localparam logic signed [56:0] RND30 = 57'sd536870912;
    localparam logic signed [44:0] RND9  = 45'sd256;

    logic [4:0] r_vld;

    logic signed [56:0] r_pc, r_ps;
    logic signed [20:0] r_tx1, r_ty1;

    logic signed [26:0] r_a2, r_b2;
    logic signed [20:0] r_tx2, r_ty2;

    logic signed [41:0] r_aw, r_bh, r_bw, r_ah;
    logic signed [26:0] r_a3, r_b3;
    logic signed [20:0] r_tx3, r_ty3;

    logic signed [44:0] r_x4, r_y4;
    logic signed [26:0] r_a4, r_b4;

    logic signed [23:0] r_m00, r_m01, r_m02, r_m10, r_m12;

    logic signed [56:0] n_pc_r, n_ps_r;
    logic signed [14:0] n_sw, n_sh;
    logic signed [44:0] n_x, n_y;

    always_comb begin
        n_pc_r = r_pc + RND30;
        n_ps_r = r_ps + RND30;
        n_sw   = $signed({1'b0, i_w});
        n_sh   = $signed({1'b0, i_h});
        n_x = 45'($signed({1'b0, i_w, 16'b0})) - 45'(r_aw) + 45'(r_bh)
            - (45'(r_tx3) <<< 9);
        n_y = 45'($signed({1'b0, i_h, 16'b0})) - 45'(r_bw) - 45'(r_ah)
            - (45'(r_ty3) <<< 9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc  <= 57'($signed({1'b0, i_s}) * i_cs);
            r_ps  <= 57'($signed({1'b0, i_s}) * i_sn);
            r_tx1 <= i_tx;
            r_ty1 <= i_ty;

            r_a2  <= n_pc_r[56:30];
            r_b2  <= n_ps_r[56:30];
            r_tx2 <= r_tx1;
            r_ty2 <= r_ty1;

            r_aw  <= 42'(r_a2 * n_sw);
            r_bh  <= 42'(r_b2 * n_sh);
            r_bw  <= 42'(r_b2 * n_sw);
            r_ah  <= 42'(r_a2 * n_sh);
            r_a3  <= r_a2;
            r_b3  <= r_b2;
            r_tx3 <= r_tx2;
            r_ty3 <= r_ty2;

            r_x4  <= n_x;
            r_y4  <= n_y;
            r_a4  <= r_a3;
            r_b4  <= r_b3;

            r_m00 <= smb_pkg::sat24(45'(r_a4));
            r_m01 <= smb_pkg::sat24(-45'(r_b4));
            r_m10 <= smb_pkg::sat24(45'(r_b4));
            r_m02 <= smb_pkg::sat24((r_x4 + RND9) >>> 9);
            r_m12 <= smb_pkg::sat24((r_y4 + RND9) >>> 9);
        end
    end

    assign o_vld = r_vld[4];
    assign o_m00 = r_m00;
    assign o_m01 = r_m01;
    assign o_m02 = r_m02;
    assign o_m10 = r_m10;
    assign o_m11 = r_m00;
    assign o_m12 = r_m12;

endmodule

/* design/stabilization_matrix_builder.sv */
// throughput: one beat per cycle while the output is not stalled
// the two 32/33-stage dividers and the cordic are fully pipelined
// the whole pipe advances together whenever the output register is empty or being taken
// synchronous active-low reset clears all valid bits and loads the register reset values
// top level: configuration registers, front and clamp stages, unit instances
module stabilization_matrix_builder #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // raw_tx, raw_ty, raw_angle, raw_scale, smooth_tx, smooth_ty, smooth_angle, smooth_scale
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m00, m01, m02, m10, m11, m12
    output logic [143:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NS = (CORDIC_STAGES < smb_pkg::ATAN_COUNT) ? CORDIC_STAGES
                                                               : smb_pkg::ATAN_COUNT;
    localparam int PW1 = 59;
    localparam int PW2 = 65;

    logic [13:0] r_width, r_height;
    logic        r_en_x, r_en_y, r_en_zoom, r_en_rot, r_en_scale;

    smb_pkg::t_cfg_idx n_idx;
    logic              en;

    assign pready = 1'b1;
    assign n_idx  = smb_pkg::t_cfg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 14'd1920;
            r_height   <= 14'd1080;
            r_en_x     <= 1'b1;
            r_en_y     <= 1'b1;
            r_en_zoom  <= 1'b1;
            r_en_rot   <= 1'b1;
            r_en_scale <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (n_idx)
                smb_pkg::CFG_FRAME_WIDTH:     r_width    <= pwdata[13:0];
                smb_pkg::CFG_FRAME_HEIGHT:    r_height   <= pwdata[13:0];
                smb_pkg::CFG_ENABLE_X:        r_en_x     <= pwdata[0];
                smb_pkg::CFG_ENABLE_Y:        r_en_y     <= pwdata[0];
                smb_pkg::CFG_ENABLE_ZOOM:     r_en_zoom  <= pwdata[0];
                smb_pkg::CFG_ENABLE_ROTATION: r_en_rot   <= pwdata[0];
                smb_pkg::CFG_ENABLE_SCALE:    r_en_scale <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            smb_pkg::CFG_FRAME_WIDTH:     prdata = {18'b0, r_width};
            smb_pkg::CFG_FRAME_HEIGHT:    prdata = {18'b0, r_height};
            smb_pkg::CFG_ENABLE_X:        prdata = {31'b0, r_en_x};
            smb_pkg::CFG_ENABLE_Y:        prdata = {31'b0, r_en_y};
            smb_pkg::CFG_ENABLE_ZOOM:     prdata = {31'b0, r_en_zoom};
            smb_pkg::CFG_ENABLE_ROTATION: prdata = {31'b0, r_en_rot};
            smb_pkg::CFG_ENABLE_SCALE:    prdata = {31'b0, r_en_scale};
            default:                      prdata = '0;
        endcase
    end

    // front stage: differences, raw scale clamp, first dividend
    logic signed [20:0] n_tx, n_ty;
    logic signed [16:0] n_rot;
    logic [15:0]        n_r;
    logic [15:0]        n_ss;

    logic               r_f_vld;
    logic signed [20:0] r_f_tx, r_f_ty;
    logic signed [16:0] r_f_rot;
    logic [15:0]        r_f_r;
    logic [31:0]        r_f_num;

    always_comb begin
        n_tx  = r_en_x ? 21'($signed(s_tdata[91:72])) - 21'($signed(s_tdata[19:0])) : '0;
        n_ty  = r_en_y ? 21'($signed(s_tdata[111:92])) - 21'($signed(s_tdata[39:20])) : '0;
        n_rot = r_en_rot ? 17'($signed(s_tdata[127:112])) - 17'($signed(s_tdata[55:40]))
                         : '0;
        n_r   = (s_tdata[71:56] < smb_pkg::RAW_MIN_Q12) ? smb_pkg::RAW_MIN_Q12
                                                        : s_tdata[71:56];
        n_ss  = s_tdata[143:128];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_tx  <= n_tx;
            r_f_ty  <= n_ty;
            r_f_rot <= n_rot;
            r_f_r   <= n_r;
            r_f_num <= {n_ss, 16'b0} + {17'b0, n_r[15:1]};
        end
    end

    logic            d1_vld;
    logic [31:0]     d1_quo;
    logic [PW1-1:0]  d1_pay;

    smb_div #(.ND(32), .DW(16), .PW(PW1)) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_f_vld),
        .i_num   (r_f_num),
        .i_den   (r_f_r),
        .i_pay   ({r_f_rot, r_f_ty, r_f_tx}),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_pay   (d1_pay)
    );

    // clamp stage: neutral scale when disabled, correction clamp, second dividend
    logic [26:0]    n_q, n_qc;
    logic           r_c_vld;
    logic [26:0]    r_c_qc;
    logic [32:0]    r_c_num;
    logic [PW1-1:0] r_c_pay;

    always_comb begin
        n_q  = (r_en_zoom || r_en_scale) ? d1_quo[26:0] : smb_pkg::UNITY_Q16;
        n_qc = (n_q < smb_pkg::CORR_MIN_Q16) ? smb_pkg::CORR_MIN_Q16 : n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_qc  <= n_qc;
            r_c_num <= {1'b1, 32'b0} + {7'b0, n_qc[26:1]};
            r_c_pay <= d1_pay;
        end
    end

    logic           d2_vld;
    logic [32:0]    d2_quo;
    logic [PW1-1:0] d2_pay;

    smb_div #(.ND(33), .DW(27), .PW(PW1)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_num   (r_c_num),
        .i_den   (r_c_qc),
        .i_pay   (r_c_pay),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_pay   (d2_pay)
    );

    logic               c_vld;
    logic signed [32:0] c_cs, c_sn;
    logic [PW2-1:0]     c_pay;

    smb_cordic #(.NS(NS), .PW(PW2)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d2_vld),
        .i_rot   ($signed(d2_pay[58:42])),
        .i_pay   ({d2_quo[22:0], d2_pay[41:0]}),
        .o_vld   (c_vld),
        .o_cs    (c_cs),
        .o_sn    (c_sn),
        .o_pay   (c_pay)
    );

    logic               mt_vld;
    logic signed [23:0] m00, m01, m02, m10, m11, m12;

    smb_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (c_vld),
        .i_s     (c_pay[64:42]),
        .i_cs    (c_cs),
        .i_sn    (c_sn),
        .i_tx    ($signed(c_pay[20:0])),
        .i_ty    ($signed(c_pay[41:21])),
        .i_w     (r_width),
        .i_h     (r_height),
        .o_vld   (mt_vld),
        .o_m00   (m00),
        .o_m01   (m01),
        .o_m02   (m02),
        .o_m10   (m10),
        .o_m11   (m11),
        .o_m12   (m12)
    );

    assign en       = !mt_vld || m_tready;
    assign s_tready = en;
    assign m_tvalid = mt_vld;
    assign m_tdata  = {m12, m11, m10, m02, m01, m00};

endmodule

/* design/smb_chk.sv */
// port-level checker for the stabilization matrix builder, with its bind
module smb_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         pready
);

    // a waiting result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // rotation part is antisymmetric and the diagonal equal
    a_rot_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[47:24] == 24'(-m_tdata[95:72]))
                     && (m_tdata[23:0] == m_tdata[119:96]))
        else $error("matrix rotation terms inconsistent");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("config port not ready");

endmodule

bind stabilization_matrix_builder smb_chk u_smb_chk (.*);

/* sim/stabilization_matrix_builder_test.sv */
// testbench for the stabilization matrix builder: directed table, random frames, matrix predictor
`timescale 1ns / 1ps

module stabilization_matrix_builder_test;

    localparam int STAGES = 16;
    localparam int N_RANDOM = 1930;

    typedef struct packed {
        logic [15:0] smooth_scale;
        logic [15:0] smooth_angle;
        logic [19:0] smooth_ty;
        logic [19:0] smooth_tx;
        logic [15:0] raw_scale;
        logic [15:0] raw_angle;
        logic [19:0] raw_ty;
        logic [19:0] raw_tx;
    } t_frame;

    typedef struct packed {
        logic [23:0] m12;
        logic [23:0] m11;
        logic [23:0] m10;
        logic [23:0] m02;
        logic [23:0] m01;
        logic [23:0] m00;
    } t_matrix;

    typedef struct {
        t_frame  frame;
        bit      known;
        t_matrix matrix;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predictor copy of the registers
    logic [13:0] frame_w;
    logic [13:0] frame_h;
    logic        use_x;
    logic        use_y;
    logic        use_zoom;
    logic        use_rot;
    logic        use_scale;

    t_matrix matrix_q[$];
    int      mismatches;
    int      matrices_seen;
    bit      out_stall_en;

    stabilization_matrix_builder #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 64'sd8388607) begin
            return 64'sd8388607;
        end
        if (v < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    function automatic longint arctan_step(input int i);
        longint t[24];
        t = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
              16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
              131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
        return t[i];
    endfunction

    function automatic t_matrix correction_matrix(input t_frame f);
        longint tx, ty, rot, r, q, qc, s, a, x, y, z, t, A, B, X, Y, w, h;
        bit flip;
        t_matrix m;
        tx = 0;
        ty = 0;
        rot = 0;
        if (use_x) tx = longint'($signed(f.smooth_tx)) - longint'($signed(f.raw_tx));
        if (use_y) ty = longint'($signed(f.smooth_ty)) - longint'($signed(f.raw_ty));
        if (use_rot) rot = longint'($signed(f.smooth_angle)) - longint'($signed(f.raw_angle));
        r = (f.raw_scale < 41) ? 41 : longint'(f.raw_scale);
        if (use_zoom || use_scale) begin
            q = ((longint'(f.smooth_scale) << 16) + r / 2) / r;
        end else begin
            q = 65536;
        end
        qc = (q < 655) ? 655 : q;
        s = ((64'sd1 << 32) + qc / 2) / qc;
        // quadrant reduction then rotation-mode cordic
        a = -rot * 131072;
        flip = 1'b0;
        if (a > 64'sd3373259426) a -= 64'sd6746518852;
        if (a < -64'sd3373259426) a += 64'sd6746518852;
        if (a > 64'sd1686629713) begin
            a -= 64'sd3373259426;
            flip = 1'b1;
        end else if (a < -64'sd1686629713) begin
            a += 64'sd3373259426;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= arctan_step(i);
            end else begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += arctan_step(i);
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        A = floor_shift(s * x + (64'sd1 << 29), 30);
        B = floor_shift(s * y + (64'sd1 << 29), 30);
        w = longint'(frame_w);
        h = longint'(frame_h);
        X = w * 65536 - A * w + B * h - tx * 512;
        Y = h * 65536 - B * w - A * h - ty * 512;
        m.m00 = 24'(clip24(A));
        m.m01 = 24'(clip24(-B));
        m.m02 = 24'(clip24(floor_shift(X + 256, 9)));
        m.m10 = 24'(clip24(B));
        m.m11 = 24'(clip24(A));
        m.m12 = 24'(clip24(floor_shift(Y + 256, 9)));
        return m;
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic random_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) begin
            return;
        end else if (p < 95) begin
            idle_cycles($urandom_range(3, 1));
        end else begin
            idle_cycles($urandom_range(40, 8));
        end
    endtask

    task automatic reg_write(input smb_pkg::t_cfg_idx idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 5'(4 * int'(idx));
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            smb_pkg::CFG_FRAME_WIDTH:     frame_w = value[13:0];
            smb_pkg::CFG_FRAME_HEIGHT:    frame_h = value[13:0];
            smb_pkg::CFG_ENABLE_X:        use_x = value[0];
            smb_pkg::CFG_ENABLE_Y:        use_y = value[0];
            smb_pkg::CFG_ENABLE_ZOOM:     use_zoom = value[0];
            smb_pkg::CFG_ENABLE_ROTATION: use_rot = value[0];
            smb_pkg::CFG_ENABLE_SCALE:    use_scale = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [13:0] w, input logic [13:0] h, input logic [4:0] en);
        reg_write(smb_pkg::CFG_FRAME_WIDTH, 32'(w));
        reg_write(smb_pkg::CFG_FRAME_HEIGHT, 32'(h));
        reg_write(smb_pkg::CFG_ENABLE_X, 32'(en[0]));
        reg_write(smb_pkg::CFG_ENABLE_Y, 32'(en[1]));
        reg_write(smb_pkg::CFG_ENABLE_ZOOM, 32'(en[2]));
        reg_write(smb_pkg::CFG_ENABLE_ROTATION, 32'(en[3]));
        reg_write(smb_pkg::CFG_ENABLE_SCALE, 32'(en[4]));
    endtask

    // drain all pending matrices, then let the pipe settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (matrix_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        idle_cycles(120);
    endtask

    task automatic send_frame(input t_frame f, input bit known, input t_matrix m);
        s_tvalid = 1'b1;
        s_tdata = f;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        matrix_q.push_back(known ? m : correction_matrix(f));
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    function automatic t_frame random_frame();
        t_frame f;
        int k;
        f = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(9);
        // mostly realistic small corrections, some full-range noise
        if (k < 6) begin
            f.raw_tx = 20'($signed($urandom_range(20000)) - 10000);
            f.smooth_tx = 20'($signed($urandom_range(20000)) - 10000);
            f.raw_ty = 20'($signed($urandom_range(20000)) - 10000);
            f.smooth_ty = 20'($signed($urandom_range(20000)) - 10000);
            f.raw_angle = 16'($signed($urandom_range(4000)) - 2000);
            f.smooth_angle = 16'($signed($urandom_range(4000)) - 2000);
            f.raw_scale = 16'($urandom_range(4600, 3600));
            f.smooth_scale = 16'($urandom_range(4600, 3600));
        end else if (k < 8) begin
            f.raw_scale = 16'($urandom_range(60));
        end
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_matrix got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            matrices_seen++;
            if (matrix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected matrix beat %h", got);
            end else begin
                want = matrix_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch m00 %h/%h m01 %h/%h m02 %h/%h",
                                 want.m00, got.m00, want.m01, got.m01, want.m02, got.m02);
                        $display("         m10 %h/%h m11 %h/%h m12 %h/%h",
                                 want.m10, got.m10, want.m11, got.m11, want.m12, got.m12);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int p;
        p = $urandom_range(99);
        if (!out_stall_en) begin
            m_tready <= 1'b1;
        end else if (p < 70) begin
            m_tready <= 1'b1;
        end else if (p < 97) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b0;
            repeat ($urandom_range(30, 5)) @(negedge i_clk);
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_matrix unity;
        t_frame f;
        int guard;
        logic [13:0] w, h;

        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        matrices_seen = 0;
        out_stall_en = 1'b0;
        frame_w = 14'd1920;
        frame_h = 14'd1080;
        use_x = 1'b1;
        use_y = 1'b1;
        use_zoom = 1'b1;
        use_rot = 1'b1;
        use_scale = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no correction after reset: unity scale, and the cordic residual at
        // zero angle leaves a one-lsb sine that shows up in the offsets
        unity.m00 = 24'd65536;
        unity.m01 = 24'd1;
        unity.m02 = 24'hFFFFFE;
        unity.m10 = 24'hFFFFFF;
        unity.m11 = 24'd65536;
        unity.m12 = 24'd4;
        row.known = 1'b1;
        row.matrix = unity;
        row.frame = '0;
        row.frame.raw_scale = 16'd4096;
        row.frame.smooth_scale = 16'd4096;
        rows.push_back(row);
        row.frame.raw_tx = 20'h12345;
        row.frame.smooth_tx = 20'h12345;
        row.frame.raw_angle = 16'h8000;
        row.frame.smooth_angle = 16'h8000;
        rows.push_back(row);
        row.known = 1'b0;
        // extremes of every field, tiny scales, large offsets
        row.frame = '0;
        row.frame.smooth_tx = 20'h7FFFF;
        row.frame.raw_tx = 20'h80000;
        row.frame.smooth_ty = 20'h80000;
        row.frame.raw_ty = 20'h7FFFF;
        row.frame.smooth_angle = 16'h7FFF;
        row.frame.raw_angle = 16'h8000;
        rows.push_back(row);
        row.frame = '1;
        rows.push_back(row);
        row.frame.raw_angle = 16'h7FFF;
        row.frame.smooth_angle = 16'h8000;
        row.frame.raw_scale = 16'd0;
        row.frame.smooth_scale = 16'hFFFF;
        rows.push_back(row);
        row.frame.raw_scale = 16'hFFFF;
        row.frame.smooth_scale = 16'd0;
        rows.push_back(row);
        row.frame.raw_scale = 16'd41;
        row.frame.smooth_scale = 16'd1;
        row.frame.raw_angle = 16'd0;
        row.frame.smooth_angle = 16'd12868;
        rows.push_back(row);
        row.frame.smooth_angle = -16'sd12868;
        rows.push_back(row);
        row.frame.smooth_angle = 16'd25736;
        rows.push_back(row);
        row.frame.smooth_angle = 16'd25737;
        rows.push_back(row);

        foreach (rows[i]) begin
            send_frame(rows[i].frame, rows[i].known, rows[i].matrix);
        end
        wait_drained();

        // each enable off, zero size, oversize frame
        set_config(14'd0, 14'd0, 5'b00000);
        for (int i = 2; i < 10; i++) send_frame(rows[i].frame, 1'b0, unity);
        wait_drained();
        set_config(14'd16383, 14'd16383, 5'b01011);
        for (int i = 2; i < 10; i++) send_frame(rows[i].frame, 1'b0, unity);
        wait_drained();
        set_config(14'd8192, 14'd1, 5'b10101);
        for (int i = 2; i < 10; i++) send_frame(rows[i].frame, 1'b0, unity);
        wait_drained();

        out_stall_en = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            w = (phase == 0) ? 14'd1 : 14'($urandom_range(8192, 1));
            h = (phase == 1) ? 14'd8192 : 14'($urandom_range(8192, 1));
            set_config(w, h, (phase < 2) ? 5'b11111 : 5'($urandom));
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                f = random_frame();
                send_frame(f, 1'b0, unity);
                // a stretch without sender gaps in each phase
                if (i > 100) random_gap();
                if (i == 200) wait_drained();
            end
            wait_drained();
        end

        guard = 0;
        while (matrix_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        idle_cycles(120);
        $display("covered %0d matrices over several frame sizes and enable settings",
                 matrices_seen);
        $display("including clamped scales, wrapped angles and saturated offsets");
        if (mismatches == 0 && matrix_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
design/smb_pkg.sv
design/smb_div.sv
design/smb_cordic.sv
design/smb_mat.sv
design/stabilization_matrix_builder.sv
design/smb_chk.sv
sim/stabilization_matrix_builder_test.sv
